FILE: sv/pbd_pkg.sv
// Shared types, constants and helper function of the polarimetric beam demodulator.
package pbd_pkg;

   // Pixel geometry and field widths.
   localparam int BEAM_COUNT    = 8;
   localparam int BEAM_IDX_BITS = 3;
   localparam int FIELD_BITS    = 24;
   localparam int OUT_BITS      = 42;
   localparam int SUM_BITS      = FIELD_BITS + BEAM_IDX_BITS;

   // Intensity mode divides by half the beam count, a power of two.
   localparam int HALF_LOG2  = 2;
   localparam int HALF_ROUND = 2;

   // The shared unit resolves one bit per cycle of a 64-bit multiplier, quotient or root.
   localparam int ALU_STEPS     = 64;
   localparam int ALU_CNT_BITS  = 6;
   localparam int ALU_X_BITS    = 128;
   localparam int ALU_Y_BITS    = 64;
   localparam int ALU_REM_BITS  = 68;

   // Demodulation modes; the unused code behaves as Stokes mode.
   localparam logic [1:0] MODE_STOKES    = 2'd0;
   localparam logic [1:0] MODE_NULL      = 2'd1;
   localparam logic [1:0] MODE_INTENSITY = 2'd2;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   // Command from the sequencer to the shared unit.
   typedef struct packed {
      logic                    start;
      alu_op_type              op;
      logic [ALU_X_BITS-1:0]   x;
      logic [ALU_Y_BITS-1:0]   y;
   } alu_req_type;

   // Status and result from the shared unit.
   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic [ALU_X_BITS-1:0]   result;
   } alu_rsp_type;

   // Finished pixel from the sequencer to the output register.
   typedef struct packed {
      logic                    valid;
      logic [OUT_BITS-1:0]     value;
      logic [OUT_BITS-1:0]     error;
      logic                    pixel_valid;
      logic                    fault;
   } pix_res_type;

   // Beam slots of the four pair products: numerator pairs (1u,2d) and (3u,4d),
   // denominator pairs (2u,1d) and (4u,3d).
   function automatic logic [BEAM_IDX_BITS-1:0] pair_addr(input logic [1:0] pair,
                                                          input logic side);
      logic [BEAM_IDX_BITS-1:0] addr;
      case (pair)
         2'd0:    addr = side ? 3'd3 : 3'd0;
         2'd1:    addr = side ? 3'd7 : 3'd4;
         2'd2:    addr = side ? 3'd1 : 3'd2;
         default: addr = side ? 3'd5 : 3'd6;
      endcase
      return addr;
   endfunction

endpackage

FILE: sv/pbd_if.sv
// Channel interfaces of the polarimetric beam demodulator: requests, results, configuration.
interface pbd_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] beam_intensity;
   logic [23:0] beam_error;
   logic        inside_overlap;

   modport source(output valid, beam_intensity, beam_error, inside_overlap, input ready);
   modport sink(input valid, beam_intensity, beam_error, inside_overlap, output ready);
endinterface

interface pbd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [41:0] demod_value;
   logic        [41:0] demod_error;
   logic               pixel_valid;
   logic               fault;

   modport source(output valid, demod_value, demod_error, pixel_valid, fault, input ready);
   modport sink(input valid, demod_value, demod_error, pixel_valid, fault, output ready);
endinterface

interface pbd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] demod_mode;

   modport source(output valid, demod_mode, input ready);
   modport sink(input valid, demod_mode, output ready);
endinterface

FILE: sv/polarimetric_beam_demodulator.sv
// A pixel is collected from eight requests; in Stokes or null mode it then takes 32 operations of
// the shared bit-serial multiply, divide and root unit plus a normalization shift, and in intensity
// mode 9. A pixel outside the overlap, or in Stokes or null mode with a zero intensity, skips them.
// No request is taken while a pixel is computed or waits for the output register to take it.
// Reset is synchronous and active high; it resets the beam count, flags and mode register.
module polarimetric_beam_demodulator #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic      clock,
   input  logic      reset,
   pbd_req_if.sink   req,
   pbd_rsp_if.source rsp,
   pbd_csr_if.sink   csr
);

   logic [1:0]                   demod_mode_ff, demod_mode_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pbd_pkg::OUT_BITS-1:0] value_ff, error_ff;
   logic                         pixel_valid_ff, fault_ff;
   logic                         req_ready;
   logic                         res_ready;
   logic                         res_load;
   pbd_pkg::pix_res_type         res;
   pbd_pkg::alu_req_type         alu_req;
   pbd_pkg::alu_rsp_type         alu_rsp;

   // Mode register, always ready for a write.
   assign csr.ready     = 1'b1;
   assign demod_mode_in = csr.valid ? csr.demod_mode : demod_mode_ff;

   pbd_seq #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .demod_mode     (demod_mode_ff),
      .req_fire       (req.valid && req_ready),
      .req_ready      (req_ready),
      .beam_intensity (req.beam_intensity),
      .beam_error     (req.beam_error),
      .inside_overlap (req.inside_overlap),
      .res_ready      (res_ready),
      .res            (res),
      .alu_req        (alu_req),
      .alu_rsp        (alu_rsp)
   );

   pbd_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req.ready = req_ready;

   // Output register: takes a finished pixel whenever it is empty or being drained.
   assign res_ready    = !rsp_valid_ff || rsp.ready;
   assign res_load     = res.valid && res_ready;
   assign rsp_valid_in = res_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         demod_mode_ff <= pbd_pkg::MODE_STOKES;
         rsp_valid_ff  <= 1'b0;
      end else begin
         demod_mode_ff <= demod_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (res_load) begin
         value_ff       <= res.value;
         error_ff       <= res.error;
         pixel_valid_ff <= res.pixel_valid;
         fault_ff       <= res.fault;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.demod_value = $signed(value_ff);
   assign rsp.demod_error = error_ff;
   assign rsp.pixel_valid = pixel_valid_ff;
   assign rsp.fault       = fault_ff;

endmodule

FILE: sv/pbd_alu.sv
// Shared bit-serial multiply, divide and square-root unit.
module pbd_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pbd_pkg::alu_req_type alu_req,
   output pbd_pkg::alu_rsp_type alu_rsp
);

   pbd_pkg::alu_op_type                        op_ff, op_in;
   logic [pbd_pkg::ALU_X_BITS-1:0]             x_ff, x_in;
   logic [pbd_pkg::ALU_Y_BITS-1:0]             y_ff, y_in;
   logic [pbd_pkg::ALU_X_BITS-1:0]             r_ff, r_in;
   logic [pbd_pkg::ALU_REM_BITS-1:0]           t_ff, t_in;
   logic [pbd_pkg::ALU_CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                                       busy_ff, busy_in;
   logic                                       done_ff, done_in;
   logic [pbd_pkg::ALU_REM_BITS-1:0]           rem;
   logic [pbd_pkg::ALU_REM_BITS-1:0]           trial;

   // One step per cycle: shift-add multiply, restoring divide, digit-by-digit root.
   always_comb begin
      op_in   = op_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      t_in    = t_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem     = '0;
      trial   = '0;
      if (!busy_ff) begin
         if (alu_req.start) begin
            op_in   = alu_req.op;
            x_in    = alu_req.x;
            y_in    = alu_req.y;
            r_in    = '0;
            t_in    = '0;
            cnt_in  = pbd_pkg::ALU_CNT_BITS'(pbd_pkg::ALU_STEPS - 1);
            busy_in = 1'b1;
         end
      end else begin
         case (op_ff)
            pbd_pkg::ALU_MUL: begin
               r_in = {r_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b0}
                    + (y_ff[pbd_pkg::ALU_Y_BITS-1]
                       ? {64'd0, x_ff[63:0]} : {pbd_pkg::ALU_X_BITS{1'b0}});
               y_in = {y_ff[pbd_pkg::ALU_Y_BITS-2:0], 1'b0};
            end
            pbd_pkg::ALU_DIV: begin
               rem  = {t_ff[pbd_pkg::ALU_REM_BITS-2:0], x_ff[63]};
               x_in = {x_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b0};
               if (rem >= {4'd0, y_ff}) begin
                  t_in = rem - {4'd0, y_ff};
                  r_in = {r_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b1};
               end else begin
                  t_in = rem;
                  r_in = {r_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b0};
               end
            end
            pbd_pkg::ALU_SQRT: begin
               rem   = {t_ff[pbd_pkg::ALU_REM_BITS-3:0], x_ff[127:126]};
               trial = {2'd0, r_ff[63:0], 2'b01};
               x_in  = {x_ff[pbd_pkg::ALU_X_BITS-3:0], 2'b00};
               if (rem >= trial) begin
                  t_in = rem - trial;
                  r_in = {r_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b1};
               end else begin
                  t_in = rem;
                  r_in = {r_ff[pbd_pkg::ALU_X_BITS-2:0], 1'b0};
               end
            end
            default: begin
               r_in = r_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state resets; operands and partial results do not need to.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff <= op_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      r_ff  <= r_in;
      t_ff  <= t_in;
   end

   assign alu_rsp.busy   = busy_ff;
   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = r_ff;

`ifndef SYNTH
   // The sequencer must never issue a new operation while one is in flight.
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !busy_ff)
      else $error("shared unit started while busy");

   // Completion is flagged only after the unit has stopped.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("shared unit done while still busy");

   // A completion always follows a final step of a running operation.
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_in |=> (done_ff && !busy_ff))
      else $error("shared unit completion lost");
`endif

endmodule

FILE: sv/pbd_seq.sv
// Sample collection, beam store and micro-sequencer that drives the shared unit.
module pbd_seq #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           demod_mode,
   input  logic                 req_fire,
   output logic                 req_ready,
   input  logic [23:0]          beam_intensity,
   input  logic [23:0]          beam_error,
   input  logic                 inside_overlap,
   input  logic                 res_ready,
   output pbd_pkg::pix_res_type res,
   output pbd_pkg::alu_req_type alu_req,
   input  pbd_pkg::alu_rsp_type alu_rsp
);

   localparam logic [23:0] SampleMask = (SAMPLE_BITS >= 24) ? {24{1'b1}}
                                      : 24'((64'd1 << SAMPLE_BITS) - 64'd1);
   localparam int FracBits = 62 - SAMPLE_BITS;
   localparam int WgShift  = FracBits + 19;
   localparam logic [127:0] WgRound = 128'd1 << (FracBits + 18);

   typedef enum logic [14:0] {
      ST_COLLECT = 15'b000000000000001,
      ST_PMUL    = 15'b000000000000010,
      ST_PSQRT   = 15'b000000000000100,
      ST_ABMUL   = 15'b000000000001000,
      ST_ABSQRT  = 15'b000000000010000,
      ST_NORM    = 15'b000000000100000,
      ST_SDIV    = 15'b000000001000000,
      ST_SSQ     = 15'b000000010000000,
      ST_TDIV    = 15'b000000100000000,
      ST_TSQ     = 15'b000001000000000,
      ST_WSQRT   = 15'b000010000000000,
      ST_WG      = 15'b000100000000000,
      ST_IMUL    = 15'b001000000000000,
      ST_ISQRT   = 15'b010000000000000,
      ST_FIN     = 15'b100000000000000
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_FETCH = 3'b001,
      PH_ISSUE = 3'b010,
      PH_WAIT  = 3'b100
   } phase_type;

   seq_state_type                          state_ff, state_in;
   phase_type                              ph_ff, ph_in;
   logic [pbd_pkg::BEAM_IDX_BITS-1:0]      cnt_ff, cnt_in;
   logic [pbd_pkg::BEAM_IDX_BITS-1:0]      j_ff, j_in;
   logic                                   ovl_ff, ovl_in;
   logic                                   zero_ff, zero_in;
   logic [pbd_pkg::SUM_BITS-1:0]           sum_ff, sum_in;
   logic                                   null_ff, null_in;
   logic [63:0]                            rt_ff [4];
   logic [63:0]                            rt_in [4];
   logic [63:0]                            a_ff, a_in, b_ff, b_in;
   logic [32:0]                            s_ff, s_in, g_ff, g_in;
   logic [127:0]                           tmp_ff, tmp_in, acc_ff, acc_in;
   logic [pbd_pkg::OUT_BITS-1:0]           val_ff, val_in, err_ff, err_in;
   logic                                   pv_ff, pv_in, flt_ff, flt_in;

   logic [47:0]                            store_mem [pbd_pkg::BEAM_COUNT];
   logic [47:0]                            rd0_ff, rd1_ff;
   logic [pbd_pkg::BEAM_IDX_BITS-1:0]      ra0, ra1;

   logic [23:0]                            mi, me;
   logic [23:0]                            rd0_i, rd0_e, rd1_i;
   logic                                   unit_st, done_now;
   logic [63:0]                            diff, sum_ab;
   logic [33:0]                            vq_sum;
   logic [17:0]                            vq;
   logic [127:0]                           wg_sum, wg_sh;
   logic [pbd_pkg::SUM_BITS-1:0]           sum_fin;
   logic [pbd_pkg::SUM_BITS+15:0]          int_val;

   assign mi    = beam_intensity & SampleMask;
   assign me    = beam_error & SampleMask;
   assign rd0_i = rd0_ff[47:24];
   assign rd0_e = rd0_ff[23:0];
   assign rd1_i = rd1_ff[47:24];

   // Beam store: one write port from the request side, two registered read ports.
   assign ra0 = (state_ff == ST_PMUL) ? pbd_pkg::pair_addr(j_ff[1:0], 1'b0) : j_ff;
   assign ra1 = pbd_pkg::pair_addr(j_ff[1:0], 1'b1);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         store_mem[cnt_ff] <= {mi, me};
      end
      rd0_ff <= store_mem[ra0];
      rd1_ff <= store_mem[ra1];
   end

   assign unit_st  = state_ff inside {ST_PMUL, ST_PSQRT, ST_ABMUL, ST_ABSQRT, ST_SDIV,
                                      ST_SSQ, ST_TDIV, ST_TSQ, ST_WSQRT, ST_WG,
                                      ST_IMUL, ST_ISQRT};
   assign done_now = unit_st && (ph_ff == PH_WAIT) && alu_rsp.done;

   // Stokes ratio pieces after normalization, error scaling and the intensity sum.
   assign diff    = (a_ff >= b_ff) ? (a_ff - b_ff) : (b_ff - a_ff);
   assign sum_ab  = a_ff + b_ff;
   assign vq_sum  = {1'b0, s_ff} + 34'd32768;
   assign vq      = vq_sum[33:16];
   assign wg_sum  = alu_rsp.result + WgRound;
   assign wg_sh   = wg_sum >> WgShift;
   assign sum_fin = sum_ff + pbd_pkg::SUM_BITS'(mi);
   assign int_val = ({sum_fin, 16'd0} + (pbd_pkg::SUM_BITS+16)'(pbd_pkg::HALF_ROUND))
                    >> pbd_pkg::HALF_LOG2;

   // Operand selection for the shared unit.
   always_comb begin
      alu_req.start = unit_st && (ph_ff == PH_ISSUE);
      alu_req.op    = pbd_pkg::ALU_MUL;
      alu_req.x     = '0;
      alu_req.y     = '0;
      case (state_ff)
         ST_PMUL: begin
            alu_req.x = 128'(rd0_i);
            alu_req.y = 64'(rd1_i);
         end
         ST_PSQRT: begin
            alu_req.op = pbd_pkg::ALU_SQRT;
            alu_req.x  = {tmp_ff[63:0], 64'd0};
         end
         ST_ABMUL: begin
            alu_req.x = j_ff[0] ? 128'(rt_ff[2]) : 128'(rt_ff[0]);
            if (j_ff[0]) begin
               alu_req.y = null_ff ? rt_ff[1] : rt_ff[3];
            end else begin
               alu_req.y = null_ff ? rt_ff[3] : rt_ff[1];
            end
         end
         ST_ABSQRT: begin
            alu_req.op = pbd_pkg::ALU_SQRT;
            alu_req.x  = tmp_ff;
         end
         ST_SDIV: begin
            alu_req.op = pbd_pkg::ALU_DIV;
            alu_req.x  = 128'((diff << 32) + (sum_ab >> 1));
            alu_req.y  = sum_ab;
         end
         ST_SSQ: begin
            alu_req.x = 128'(s_ff);
            alu_req.y = 64'(s_ff);
         end
         ST_TDIV: begin
            alu_req.op = pbd_pkg::ALU_DIV;
            alu_req.x  = 128'(64'(rd0_e) << FracBits);
            alu_req.y  = 64'(rd0_i);
         end
         ST_TSQ: begin
            alu_req.x = {64'd0, tmp_ff[63:0]};
            alu_req.y = tmp_ff[63:0];
         end
         ST_WSQRT: begin
            alu_req.op = pbd_pkg::ALU_SQRT;
            alu_req.x  = acc_ff;
         end
         ST_WG: begin
            alu_req.x = {64'd0, tmp_ff[63:0]};
            alu_req.y = 64'(g_ff);
         end
         ST_IMUL: begin
            alu_req.x = 128'(rd0_e);
            alu_req.y = 64'(rd0_e);
         end
         ST_ISQRT: begin
            alu_req.op = pbd_pkg::ALU_SQRT;
            alu_req.x  = acc_ff << 32;
         end
         default: begin
            alu_req.start = 1'b0;
         end
      endcase
   end

   // Sequencer: collect eight samples, then walk the pixel math one operation at a time or go straight to the result.
   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      ovl_in   = ovl_ff;
      zero_in  = zero_ff;
      sum_in   = sum_ff;
      null_in  = null_ff;
      rt_in    = rt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      s_in     = s_ff;
      g_in     = g_ff;
      tmp_in   = tmp_ff;
      acc_in   = acc_ff;
      val_in   = val_ff;
      err_in   = err_ff;
      pv_in    = pv_ff;
      flt_in   = flt_ff;

      if (unit_st) begin
         case (ph_ff)
            PH_FETCH: ph_in = PH_ISSUE;
            PH_ISSUE: ph_in = PH_WAIT;
            PH_WAIT:  ph_in = alu_rsp.done ? PH_FETCH : PH_WAIT;
            default:  ph_in = PH_FETCH;
         endcase
      end

      case (state_ff)
         ST_COLLECT: begin
            if (req_fire) begin
               cnt_in  = cnt_ff + 1'b1;
               ovl_in  = ovl_ff & inside_overlap;
               zero_in = zero_ff | (mi == '0);
               sum_in  = sum_fin;
               if (cnt_ff == pbd_pkg::BEAM_IDX_BITS'(pbd_pkg::BEAM_COUNT - 1)) begin
                  ovl_in  = 1'b1;
                  zero_in = 1'b0;
                  sum_in  = '0;
                  null_in = (demod_mode == pbd_pkg::MODE_NULL);
                  val_in  = '0;
                  err_in  = '0;
                  pv_in   = ovl_ff & inside_overlap;
                  flt_in  = 1'b0;
                  j_in    = '0;
                  acc_in  = '0;
                  ph_in   = PH_FETCH;
                  if (!(ovl_ff & inside_overlap)) begin
                     state_in = ST_FIN;
                  end else if (demod_mode == pbd_pkg::MODE_INTENSITY) begin
                     val_in   = pbd_pkg::OUT_BITS'(int_val);
                     state_in = ST_IMUL;
                  end else if (zero_ff || (mi == '0)) begin
                     flt_in   = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     state_in = ST_PMUL;
                  end
               end
            end
         end
         ST_PMUL: begin
            if (done_now) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_PSQRT;
            end
         end
         ST_PSQRT: begin
            if (done_now) begin
               rt_in[j_ff[1:0]] = alu_rsp.result[63:0];
               if (j_ff == 3'd3) begin
                  j_in     = '0;
                  state_in = ST_ABMUL;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PMUL;
               end
            end
         end
         ST_ABMUL: begin
            if (done_now) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_ABSQRT;
            end
         end
         ST_ABSQRT: begin
            if (done_now) begin
               if (j_ff[0]) begin
                  b_in     = alu_rsp.result[63:0];
                  state_in = ST_NORM;
               end else begin
                  a_in     = alu_rsp.result[63:0];
                  j_in     = 3'd1;
                  state_in = ST_ABMUL;
               end
            end
         end
         ST_NORM: begin
            // Shift both roots right together until the larger fits in 31 bits.
            if (((a_ff | b_ff) >> 31) != '0) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
            end else begin
               ph_in    = PH_FETCH;
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (done_now) begin
               s_in     = alu_rsp.result[32:0];
               state_in = ST_SSQ;
            end
         end
         ST_SSQ: begin
            if (done_now) begin
               g_in     = s_ff[32] ? 33'd0
                          : (33'h1_0000_0000 - {1'b0, alu_rsp.result[63:32]});
               val_in   = (a_ff >= b_ff) ? pbd_pkg::OUT_BITS'(vq)
                          : (pbd_pkg::OUT_BITS'(0) - pbd_pkg::OUT_BITS'(vq));
               j_in     = '0;
               acc_in   = '0;
               state_in = ST_TDIV;
            end
         end
         ST_TDIV: begin
            if (done_now) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_TSQ;
            end
         end
         ST_TSQ: begin
            if (done_now) begin
               acc_in = acc_ff + alu_rsp.result;
               if (j_ff == pbd_pkg::BEAM_IDX_BITS'(pbd_pkg::BEAM_COUNT - 1)) begin
                  state_in = ST_WSQRT;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_TDIV;
               end
            end
         end
         ST_WSQRT: begin
            if (done_now) begin
               tmp_in   = alu_rsp.result;
               state_in = ST_WG;
            end
         end
         ST_WG: begin
            if (done_now) begin
               if (wg_sh[127:pbd_pkg::OUT_BITS] != '0) begin
                  err_in = '1;
                  flt_in = 1'b1;
               end else begin
                  err_in = wg_sh[pbd_pkg::OUT_BITS-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_IMUL: begin
            if (done_now) begin
               acc_in = acc_ff + alu_rsp.result;
               if (j_ff == pbd_pkg::BEAM_IDX_BITS'(pbd_pkg::BEAM_COUNT - 1)) begin
                  state_in = ST_ISQRT;
               end else begin
                  j_in     = j_ff + 1'b1;
               end
            end
         end
         ST_ISQRT: begin
            if (done_now) begin
               if (alu_rsp.result[63:pbd_pkg::OUT_BITS] != '0) begin
                  err_in = '1;
                  flt_in = 1'b1;
               end else begin
                  err_in = alu_rsp.result[pbd_pkg::OUT_BITS-1:0];
               end
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (res_ready) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         ph_ff    <= PH_FETCH;
         cnt_ff   <= '0;
         j_ff     <= '0;
         ovl_ff   <= 1'b1;
         zero_ff  <= 1'b0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
         j_ff     <= j_in;
         ovl_ff   <= ovl_in;
         zero_ff  <= zero_in;
         sum_ff   <= sum_in;
      end
      null_ff <= null_in;
      rt_ff   <= rt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      s_ff    <= s_in;
      g_ff    <= g_in;
      tmp_ff  <= tmp_in;
      acc_ff  <= acc_in;
      val_ff  <= val_in;
      err_ff  <= err_in;
      pv_ff   <= pv_in;
      flt_ff  <= flt_in;
   end

   assign req_ready       = (state_ff == ST_COLLECT);
   assign res.valid       = (state_ff == ST_FIN);
   assign res.value       = val_ff;
   assign res.error       = err_ff;
   assign res.pixel_valid = pv_ff;
   assign res.fault       = flt_ff;

endmodule

FILE: verif/pbd_tb_if.sv
// Result type shared by the testbench of the polarimetric beam demodulator.
package pbd_tb_types;

   // One finished pixel as it appears on the result channel.
   typedef struct packed {
      logic signed [pbd_pkg::OUT_BITS-1:0] value;
      logic        [pbd_pkg::OUT_BITS-1:0] error;
      logic                                pixel_valid;
      logic                                fault;
   } pixel_result_type;
endpackage

FILE: verif/testbench.sv
// Self-checking testbench of the polarimetric beam demodulator with a bit-exact pixel predictor.
module testbench;

   localparam int      FIELD_BITS  = pbd_pkg::FIELD_BITS;
   localparam int      BEAM_COUNT  = pbd_pkg::BEAM_COUNT;
   localparam logic [1:0] MODE_STOKES    = pbd_pkg::MODE_STOKES;
   localparam logic [1:0] MODE_NULL      = pbd_pkg::MODE_NULL;
   localparam logic [1:0] MODE_INTENSITY = pbd_pkg::MODE_INTENSITY;
   // The unused mode code, which the block treats as Stokes mode.
   localparam logic [1:0] MODE_SPARE     = 2'd3;
   localparam int      F_BITS      = 62 - FIELD_BITS;
   localparam longint  RUN_LIMIT   = 6000000;
   localparam int      SETTLE      = 2300;
   localparam logic [63:0] MAX_U42 = (64'd1 << 42) - 1;
   localparam logic [63:0] MAX_S42 = (64'd1 << 41) - 1;

   logic clock;
   logic reset;

   pbd_req_if req();
   pbd_rsp_if rsp();
   pbd_csr_if csr();

   polarimetric_beam_demodulator dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr)
   );

   // Shadow state of the block.
   logic [FIELD_BITS-1:0] beam_int [BEAM_COUNT];
   logic [FIELD_BITS-1:0] beam_err [BEAM_COUNT];
   int                    beam_slot;
   logic                  overlap_acc;
   logic [1:0]            mode_shadow;

   pbd_tb_types::pixel_result_type expected_pixels[$];
   int     mismatch_count;
   int     pixels_checked;
   int     beams_sent;
   int     faults_seen;
   int     src_idle_pct;
   int     rcv_idle_pct;
   longint cycle_count;

   // Clock generation.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
                  expected_pixels.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver backpressure.
   always @(posedge clock) begin
      if (reset)
         rsp.ready <= 1'b0;
      else
         rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   function automatic logic [63:0] int_sqrt(input logic [127:0] x);
      logic [63:0]  root;
      logic [127:0] cand;
      root = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         cand = 128'(root | (64'd1 << bit_pos));
         if (cand * cand <= x)
            root = cand[63:0];
      end
      return root;
   endfunction

   // Stokes or null ratio from the pair products, and its propagated error.
   function automatic pbd_tb_types::pixel_result_type polar_result(input logic null_mode);
      pbd_tb_types::pixel_result_type res;
      logic [63:0]  sp, sq, su, sv, a, b, m, sum, diff, s, vq, g, t, w;
      logic [127:0] acc, prod;
      int           k;
      res = '0;
      res.pixel_valid = 1'b1;
      for (int j = 0; j < BEAM_COUNT; j++)
         if (beam_int[j] == 0) begin
            res.fault = 1'b1;
            return res;
         end
      sp = int_sqrt((128'(beam_int[0]) * beam_int[3]) << 64);
      sq = int_sqrt((128'(beam_int[4]) * beam_int[7]) << 64);
      su = int_sqrt((128'(beam_int[2]) * beam_int[1]) << 64);
      sv = int_sqrt((128'(beam_int[6]) * beam_int[5]) << 64);
      if (null_mode) begin
         t  = sq;
         sq = sv;
         sv = t;
      end
      a = int_sqrt(128'(sp) * sq);
      b = int_sqrt(128'(su) * sv);
      // Common scaling keeps the larger root under 2^31.
      m = a | b;
      k = 0;
      while ((m >> k) >= 64'h8000_0000)
         k++;
      a = a >> k;
      b = b >> k;
      sum  = a + b;
      diff = (a >= b) ? a - b : b - a;
      s    = ((diff << 32) + (sum >> 1)) / sum;
      vq   = (s + 64'h8000) >> 16;
      res.value = (a >= b) ? vq[41:0] : 42'(64'd0 - vq);
      if (s >= 64'h1_0000_0000)
         g = '0;
      else
         g = 64'h1_0000_0000 - 64'((128'(s) * s) >> 32);
      // Relative errors summed in quadrature.
      acc = '0;
      for (int j = 0; j < BEAM_COUNT; j++) begin
         t   = (64'(beam_err[j]) << F_BITS) / beam_int[j];
         acc = acc + 128'(t) * t;
      end
      w    = int_sqrt(acc);
      prod = (128'(w) * g + (128'd1 << (F_BITS + 18))) >> (F_BITS + 19);
      if (prod > MAX_U42) begin
         res.error = MAX_U42[41:0];
         res.fault = 1'b1;
      end else
         res.error = prod[41:0];
      return res;
   endfunction

   // Intensity sum over all beams divided by half the beam count, error summed in quadrature.
   function automatic pbd_tb_types::pixel_result_type intensity_result();
      pbd_tb_types::pixel_result_type res;
      logic [63:0]  sum, v, e;
      logic [127:0] acc;
      res = '0;
      res.pixel_valid = 1'b1;
      sum = '0;
      acc = '0;
      for (int j = 0; j < BEAM_COUNT; j++) begin
         sum = sum + beam_int[j];
         acc = acc + 128'(beam_err[j]) * beam_err[j];
      end
      v = ((sum << 16) + 64'd2) / 64'd4;
      if (v > MAX_S42) begin
         v = MAX_S42;
         res.fault = 1'b1;
      end
      res.value = v[41:0];
      e = int_sqrt(acc << 32);
      if (e > MAX_U42) begin
         e = MAX_U42;
         res.fault = 1'b1;
      end
      res.error = e[41:0];
      return res;
   endfunction

   // Records one accepted beam and predicts the pixel when it completes.
   task automatic record_beam(input logic [23:0] inten, input logic [23:0] err,
                              input logic ovl);
      pbd_tb_types::pixel_result_type res;
      beam_int[beam_slot] = inten;
      beam_err[beam_slot] = err;
      overlap_acc = overlap_acc & ovl;
      beam_slot++;
      beams_sent++;
      if (beam_slot == BEAM_COUNT) begin
         beam_slot = 0;
         res = '0;
         if (overlap_acc) begin
            if (mode_shadow == MODE_INTENSITY)
               res = intensity_result();
            else
               res = polar_result(mode_shadow == MODE_NULL);
         end
         overlap_acc = 1'b1;
         expected_pixels.push_back(res);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch pixel %0d %s: got %h expected %h", pixels_checked, what, got, want);
   endtask

   // Result checker.
   always @(posedge clock) begin
      pbd_tb_types::pixel_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_pixels.size() == 0)
            report_mismatch("unexpected result", 64'(rsp.demod_value), 64'd0);
         else begin
            want = expected_pixels.pop_front();
            if (rsp.demod_value !== want.value)
               report_mismatch("value", 64'(rsp.demod_value), 64'(want.value));
            if (rsp.demod_error !== want.error)
               report_mismatch("error", 64'(rsp.demod_error), 64'(want.error));
            if (rsp.pixel_valid !== want.pixel_valid)
               report_mismatch("pixel_valid", 64'(rsp.pixel_valid), 64'(want.pixel_valid));
            if (rsp.fault !== want.fault)
               report_mismatch("fault", 64'(rsp.fault), 64'(want.fault));
            if (want.fault)
               faults_seen++;
         end
         pixels_checked++;
      end
   end

   // Sends one beam request; valid stays high afterwards until the next request or a pause.
   task automatic send_beam(input logic [23:0] inten, input logic [23:0] err,
                            input logic ovl);
      if ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < src_idle_pct);
      end
      req.valid          <= 1'b1;
      req.beam_intensity <= inten;
      req.beam_error     <= err;
      req.inside_overlap <= ovl;
      do
         @(posedge clock);
      while (!req.ready);
      record_beam(inten, err, ovl);
   endtask

   task automatic send_pixel(input logic [23:0] inten [BEAM_COUNT],
                             input logic [23:0] err [BEAM_COUNT],
                             input logic [BEAM_COUNT-1:0] ovl);
      for (int j = 0; j < BEAM_COUNT; j++)
         send_beam(inten[j], err[j], ovl[j]);
   endtask

   // Lowers valid and waits until every predicted pixel has arrived.
   task automatic drain_pixels(input int settle);
      req.valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      drain_pixels(SETTLE);
      csr.valid      <= 1'b1;
      csr.demod_mode <= mode;
      do
         @(posedge clock);
      while (!csr.ready);
      mode_shadow = mode;
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic uniform_pixel(input logic [23:0] iv, input logic [23:0] ev,
                                input logic [BEAM_COUNT-1:0] ovl);
      logic [23:0] ia [BEAM_COUNT];
      logic [23:0] ea [BEAM_COUNT];
      for (int j = 0; j < BEAM_COUNT; j++) begin
         ia[j] = iv;
         ea[j] = ev;
      end
      send_pixel(ia, ea, ovl);
   endtask

   // Field extremes in Stokes mode: full scale, tiny intensity with huge error, alternating extremes, a zero.
   task automatic test_extremes();
      logic [23:0] ia [BEAM_COUNT];
      logic [23:0] ea [BEAM_COUNT];
      write_mode(MODE_STOKES);
      uniform_pixel(24'hFF_FFFF, 24'hFF_FFFF, '1);
      uniform_pixel(24'd1, 24'hFF_FFFF, '1);
      for (int j = 0; j < BEAM_COUNT; j++) begin
         ia[j] = (j % 2 == 0) ? 24'hFF_FFFF : 24'd1;
         ea[j] = 24'd0;
      end
      send_pixel(ia, ea, '1);
      ia[5] = 24'd0;
      send_pixel(ia, ea, '1);
   endtask

   // Null and intensity modes, the spare code, a pixel outside the overlap and a mode change inside a pixel.
   task automatic test_modes();
      logic [23:0] ia [BEAM_COUNT];
      logic [23:0] ea [BEAM_COUNT];
      for (int j = 0; j < BEAM_COUNT; j++) begin
         ia[j] = 24'(1000 * (j + 1));
         ea[j] = 24'(37 * (j + 3));
      end
      write_mode(MODE_NULL);
      send_pixel(ia, ea, '1);
      write_mode(MODE_INTENSITY);
      uniform_pixel(24'hFF_FFFF, 24'hFF_FFFF, '1);
      ia[2] = 24'd0;
      send_pixel(ia, ea, '1);
      write_mode(MODE_SPARE);
      send_pixel(ia, ea, 8'b1110_1111);
      ia[2] = 24'd5;
      send_pixel(ia, ea, '1);
      for (int j = 0; j < 4; j++)
         send_beam(ia[j], ea[j], 1'b1);
      write_mode(MODE_INTENSITY);
      for (int j = 4; j < BEAM_COUNT; j++)
         send_beam(ia[j], ea[j], 1'b1);
   endtask

   task automatic random_pixel();
      logic [23:0] ia [BEAM_COUNT];
      logic [23:0] ea [BEAM_COUNT];
      logic [BEAM_COUNT-1:0] ovl;
      int kind;
      int base;
      kind = $urandom_range(99);
      base = $urandom_range(24'hFF_FFFF, 1);
      for (int j = 0; j < BEAM_COUNT; j++) begin
         if (kind < 55)
            ia[j] = 24'($urandom_range(24'hFF_FFFF, 1));
         else if (kind < 80)
            ia[j] = 24'($urandom_range(255, 1));
         else
            ia[j] = 24'(base) ^ 24'($urandom_range(15));
         if (ia[j] == 0)
            ia[j] = 24'd1;
         ea[j] = 24'($urandom) >> $urandom_range(23);
      end
      if ($urandom_range(99) < 4)
         ia[$urandom_range(BEAM_COUNT - 1)] = 24'd0;
      ovl = '1;
      if ($urandom_range(99) < 6)
         ovl[$urandom_range(BEAM_COUNT - 1)] = 1'b0;
      send_pixel(ia, ea, ovl);
   endtask

   // Random pixels, with a randomly chosen mode code written before every twentieth pixel.
   task automatic test_random(input int pixels);
      for (int n = 0; n < pixels; n++) begin
         if (n % 20 == 0)
            write_mode(2'($urandom_range(3)));
         // Occasionally hold the sender until the block has caught up.
         if (n % 31 == 15)
            drain_pixels(0);
         random_pixel();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req.valid          = 1'b0;
      req.beam_intensity = '0;
      req.beam_error     = '0;
      req.inside_overlap = 1'b0;
      csr.valid          = 1'b0;
      csr.demod_mode     = MODE_STOKES;
      rsp.ready          = 1'b0;
      beam_slot          = 0;
      overlap_acc        = 1'b1;
      mode_shadow        = MODE_STOKES;
      mismatch_count     = 0;
      pixels_checked     = 0;
      beams_sent         = 0;
      faults_seen        = 0;
      cycle_count        = 0;
      src_idle_pct       = 27;
      rcv_idle_pct       = 84;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_modes();
      test_random(75);
      src_idle_pct = 84;
      rcv_idle_pct = 27;
      test_random(75);
      src_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random(75);
      drain_pixels(SETTLE);

      $display("covered %0d beam requests and %0d pixels (%0d with fault) in all four mode codes",
               beams_sent, pixels_checked, faults_seen);
      $display("including overlap gaps, zero intensities, full-scale fields and a mid-pixel mode write");
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
